[design/cpas_pkg.sv]
// package for the cascaded angle/speed pid block
// holds payload types, opcode and register index codes, and loop limits
// no dependencies
package cpas_pkg;

   // opcodes
   localparam logic [1:0] OP_ANGLE      = 2'd0;
   localparam logic [1:0] OP_SPEED      = 2'd1;
   localparam logic [1:0] OP_LOAD_SPEED = 2'd2;

   // configuration register indexes
   localparam int CSR_ADDR_W = 3;
   localparam logic [CSR_ADDR_W-1:0] CSR_ANGLE_P_GAIN      = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_ANGLE_I_GAIN      = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_ANGLE_D_GAIN      = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_SPEED_P_GAIN      = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_SPEED_I_GAIN      = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_SPEED_D_GAIN      = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] CSR_DRIVE_UPPER_LIMIT = 3'd6;
   localparam logic [CSR_ADDR_W-1:0] CSR_DRIVE_LOWER_LIMIT = 3'd7;

   // integral and speed target limits
   localparam logic signed [31:0] ANGLE_INT_HIGH = 32'sd1048576;
   localparam logic signed [31:0] ANGLE_INT_LOW  = -32'sd1048576;
   localparam logic signed [31:0] SPEED_INT_HIGH = 32'sd1048576;
   localparam logic signed [31:0] SPEED_INT_LOW  = -32'sd1048576;
   localparam logic signed [15:0] SPEED_SET_HIGH = 16'sd32767;
   localparam logic signed [15:0] SPEED_SET_LOW  = -16'sd32768;

   localparam logic signed [15:0] DRIVE_UPPER_RESET = 16'sd32767;
   localparam logic signed [15:0] DRIVE_LOWER_RESET = -16'sd32768;

   typedef struct packed {
      logic [1:0]         opcode;
      logic signed [15:0] angle_setpoint;
      logic signed [15:0] measured_angle;
      logic signed [15:0] measured_speed;
      logic signed [15:0] external_speed_setpoint;
   } req_payload_type;

   typedef struct packed {
      logic               loop_ran;
      logic signed [15:0] speed_setpoint_now;
      logic signed [15:0] drive_value;
   } rsp_payload_type;

   typedef struct packed {
      logic [CSR_ADDR_W-1:0] addr;
      logic signed [15:0]    wdata;
   } csr_payload_type;

   // operands of one pid pass
   typedef struct packed {
      logic signed [15:0] target;
      logic signed [15:0] measured;
      logic signed [15:0] p_gain;
      logic signed [15:0] i_gain;
      logic signed [15:0] d_gain;
      logic signed [16:0] prev_error;
      logic signed [31:0] integral;
      logic signed [31:0] int_high;
      logic signed [31:0] int_low;
   } pid_in_type;

   // results of one pid pass
   typedef struct packed {
      logic signed [16:0] error;
      logic signed [31:0] integral;
      logic signed [15:0] sum;
   } pid_out_type;

endpackage

[design/cpas_channels.sv]
// valid/ready channel interfaces for the cascaded angle/speed pid block
// depends on cpas_pkg for the payload types
interface cpas_req_if;
   import cpas_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface cpas_rsp_if;
   import cpas_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface cpas_csr_if;
   import cpas_pkg::*;
   logic            valid;
   logic            ready;
   csr_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[design/cpas_pid_core.sv]
// one positional pid pass: error, clamped integral, three q8.8 products,
// floor shift by 8 and 16-bit saturation; depends on cpas_pkg
module cpas_pid_core (
   input  cpas_pkg::pid_in_type  pid_in,
   output cpas_pkg::pid_out_type pid_out
);
   import cpas_pkg::*;

   logic signed [16:0] err;
   logic signed [17:0] diff;
   logic signed [32:0] acc_raw;
   logic signed [32:0] acc;
   logic signed [32:0] prod_p;
   logic signed [47:0] prod_i;
   logic signed [33:0] prod_d;
   logic signed [41:0] sum;

   always_comb begin
      err     = 17'(pid_in.target) - 17'(pid_in.measured);
      diff    = 18'(err) - 18'(pid_in.prev_error);
      acc_raw = 33'(pid_in.integral) + 33'(err);
      acc     = acc_raw;
      // upper test first, then lower
      if (acc >= 33'(pid_in.int_high)) begin
         acc = 33'(pid_in.int_high);
      end
      if (acc <= 33'(pid_in.int_low)) begin
         acc = 33'(pid_in.int_low);
      end

      prod_p = 33'(pid_in.p_gain) * 33'(err);
      prod_i = 48'(pid_in.i_gain) * 48'(acc);
      prod_d = 34'(pid_in.d_gain) * 34'(diff);

      // dropping the low 8 bits rounds toward minus infinity
      sum = 42'($signed(prod_p[32:8])) + 42'($signed(prod_i[47:8]))
          + 42'($signed(prod_d[33:8]));

      pid_out.error    = err;
      pid_out.integral = acc[31:0];
      if (sum > 42'sd32767) begin
         pid_out.sum = 16'sd32767;
      end else if (sum < -42'sd32768) begin
         pid_out.sum = -16'sd32768;
      end else begin
         pid_out.sum = sum[15:0];
      end
   end

endmodule

[design/cascaded_pid_angle_speed.sv]
// top level of the cascaded angle/speed pid block
// depends on cpas_pkg, cpas_channels (interfaces) and cpas_pid_core
//
//   channel    direction  carries
//   req_chan   in         opcode, angle/speed readings, external speed target
//   rsp_chan   out        loop_ran, speed_setpoint_now, drive_value
//   csr_chan   in         register index and write data, always ready
//
// a transaction is registered on accept, then computed and registered again in
// the output register; one per cycle sustained while rsp_chan is ready.
// the pid pass updates the loop state in the same cycle, so the next request
// sees it without forwarding. reset clears loop state and restores defaults.
// a stalled result holds in the output register; the input register still
// takes one more request, after which req_chan.ready drops.
module cascaded_pid_angle_speed (
   input  logic              clock,
   input  logic              reset,
   cpas_req_if.sink          req_chan,
   cpas_rsp_if.source        rsp_chan,
   cpas_csr_if.sink          csr_chan
);
   import cpas_pkg::*;

   function automatic logic signed [15:0] clamp16(input logic signed [15:0] v,
                                                  input logic signed [15:0] hi,
                                                  input logic signed [15:0] lo);
      logic signed [15:0] r;
      r = v;
      if (r >= hi) r = hi;
      if (r <= lo) r = lo;
      return r;
   endfunction

   // configuration registers
   logic signed [15:0] angle_p_gain_ff, angle_i_gain_ff, angle_d_gain_ff;
   logic signed [15:0] speed_p_gain_ff, speed_i_gain_ff, speed_d_gain_ff;
   logic signed [15:0] drive_upper_ff, drive_lower_ff;

   // loop state
   logic signed [16:0] angle_prev_ff, angle_prev_in;
   logic signed [31:0] angle_int_ff, angle_int_in;
   logic signed [16:0] speed_prev_ff, speed_prev_in;
   logic signed [31:0] speed_int_ff, speed_int_in;
   logic signed [15:0] speed_set_ff, speed_set_in;
   logic signed [15:0] drive_ff, drive_in;

   // pipeline registers
   logic            s1_valid_ff;
   req_payload_type s1_data_ff;
   logic            out_valid_ff;
   rsp_payload_type out_data_ff, out_data_in;

   logic               advance;
   logic               is_speed;
   logic               do_load;
   logic signed [15:0] speed_ref;
   pid_in_type         pid_in;
   pid_out_type        pid_out;

   assign advance        = s1_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || advance;
   assign csr_chan.ready = 1'b1;
   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_data_ff;

   // opcode decode; the unused top code also loads the target
   always_comb begin
      unique case (s1_data_ff.opcode)
         OP_ANGLE: begin
            is_speed = 1'b0;
            do_load  = 1'b0;
         end
         OP_SPEED: begin
            is_speed = 1'b1;
            do_load  = 1'b0;
         end
         default: begin
            is_speed = 1'b1;
            do_load  = 1'b1;
         end
      endcase
   end

   assign speed_ref = do_load ? s1_data_ff.external_speed_setpoint : speed_set_ff;

   always_comb begin
      if (is_speed) begin
         pid_in.target     = speed_ref;
         pid_in.measured   = s1_data_ff.measured_speed;
         pid_in.p_gain     = speed_p_gain_ff;
         pid_in.i_gain     = speed_i_gain_ff;
         pid_in.d_gain     = speed_d_gain_ff;
         pid_in.prev_error = speed_prev_ff;
         pid_in.integral   = speed_int_ff;
         pid_in.int_high   = SPEED_INT_HIGH;
         pid_in.int_low    = SPEED_INT_LOW;
      end else begin
         pid_in.target     = s1_data_ff.angle_setpoint;
         pid_in.measured   = s1_data_ff.measured_angle;
         pid_in.p_gain     = angle_p_gain_ff;
         pid_in.i_gain     = angle_i_gain_ff;
         pid_in.d_gain     = angle_d_gain_ff;
         pid_in.prev_error = angle_prev_ff;
         pid_in.integral   = angle_int_ff;
         pid_in.int_high   = ANGLE_INT_HIGH;
         pid_in.int_low    = ANGLE_INT_LOW;
      end
   end

   cpas_pid_core u_core (
      .pid_in  (pid_in),
      .pid_out (pid_out)
   );

   always_comb begin
      angle_prev_in = angle_prev_ff;
      angle_int_in  = angle_int_ff;
      speed_prev_in = speed_prev_ff;
      speed_int_in  = speed_int_ff;
      speed_set_in  = speed_set_ff;
      drive_in      = drive_ff;
      if (advance) begin
         if (is_speed) begin
            speed_set_in  = speed_ref;
            speed_prev_in = pid_out.error;
            speed_int_in  = pid_out.integral;
            drive_in      = clamp16(pid_out.sum, drive_upper_ff, drive_lower_ff);
         end else begin
            angle_prev_in = pid_out.error;
            angle_int_in  = pid_out.integral;
            speed_set_in  = clamp16(pid_out.sum, SPEED_SET_HIGH, SPEED_SET_LOW);
         end
      end
      out_data_in.loop_ran           = is_speed;
      out_data_in.speed_setpoint_now = speed_set_in;
      out_data_in.drive_value        = drive_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         angle_prev_ff <= '0;
         angle_int_ff  <= '0;
         speed_prev_ff <= '0;
         speed_int_ff  <= '0;
         speed_set_ff  <= '0;
         drive_ff      <= '0;
      end else begin
         if (req_chan.ready) begin
            s1_valid_ff <= req_chan.valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
         angle_prev_ff <= angle_prev_in;
         angle_int_ff  <= angle_int_in;
         speed_prev_ff <= speed_prev_in;
         speed_int_ff  <= speed_int_in;
         speed_set_ff  <= speed_set_in;
         drive_ff      <= drive_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         s1_data_ff <= req_chan.payload;
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_p_gain_ff <= '0;
         angle_i_gain_ff <= '0;
         angle_d_gain_ff <= '0;
         speed_p_gain_ff <= '0;
         speed_i_gain_ff <= '0;
         speed_d_gain_ff <= '0;
         drive_upper_ff  <= DRIVE_UPPER_RESET;
         drive_lower_ff  <= DRIVE_LOWER_RESET;
      end else if (csr_chan.valid && csr_chan.ready) begin
         unique case (csr_chan.payload.addr)
            CSR_ANGLE_P_GAIN:      angle_p_gain_ff <= csr_chan.payload.wdata;
            CSR_ANGLE_I_GAIN:      angle_i_gain_ff <= csr_chan.payload.wdata;
            CSR_ANGLE_D_GAIN:      angle_d_gain_ff <= csr_chan.payload.wdata;
            CSR_SPEED_P_GAIN:      speed_p_gain_ff <= csr_chan.payload.wdata;
            CSR_SPEED_I_GAIN:      speed_i_gain_ff <= csr_chan.payload.wdata;
            CSR_SPEED_D_GAIN:      speed_d_gain_ff <= csr_chan.payload.wdata;
            CSR_DRIVE_UPPER_LIMIT: drive_upper_ff  <= csr_chan.payload.wdata;
            CSR_DRIVE_LOWER_LIMIT: drive_lower_ff  <= csr_chan.payload.wdata;
            default: ;
         endcase
      end
   end

endmodule

[bench/pid_response_checker.sv]
// checker for the cascaded angle/speed pid block: watches all three channels,
// predicts each result from its own copy of loop state and registers, compares
// depends on cpas_pkg and the channel interfaces in cpas_channels
module pid_response_checker (
   input  logic clock,
   input  logic reset,
   cpas_req_if  req_mon,
   cpas_rsp_if  rsp_mon,
   cpas_csr_if  csr_mon,
   output int   fail_count,
   output int   pending_count
);
   import cpas_pkg::*;

   typedef struct packed {
      logic signed [16:0] err;
      logic signed [31:0] acc;
      logic signed [15:0] sum;
   } loop_step_type;

   logic signed [15:0] gain_reg [CSR_ANGLE_P_GAIN:CSR_SPEED_D_GAIN];
   logic signed [15:0] drive_hi_q;
   logic signed [15:0] drive_lo_q;

   logic signed [16:0] angle_err_q;
   logic signed [31:0] angle_acc_q;
   logic signed [16:0] speed_err_q;
   logic signed [31:0] speed_acc_q;
   logic signed [15:0] speed_ref_q;
   logic signed [15:0] drive_q;

   rsp_payload_type loop_results_due [$];

   // one positional pid pass; products floor-shifted by 8, sum saturated to 16 bits
   function automatic loop_step_type pid_loop_step(
      input logic signed [15:0] target,
      input logic signed [15:0] measured,
      input logic signed [15:0] kp,
      input logic signed [15:0] ki,
      input logic signed [15:0] kd,
      input logic signed [16:0] prev_err,
      input logic signed [31:0] prev_acc,
      input logic signed [31:0] acc_hi,
      input logic signed [31:0] acc_lo
   );
      longint        e;
      longint        d;
      longint        acc;
      longint        total;
      loop_step_type r;
      e   = longint'(target) - longint'(measured);
      d   = e - longint'(prev_err);
      acc = longint'(prev_acc) + e;
      if (acc >= longint'(acc_hi)) acc = longint'(acc_hi);
      if (acc <= longint'(acc_lo)) acc = longint'(acc_lo);
      total = ((longint'(kp) * e) >>> 8) + ((longint'(ki) * acc) >>> 8)
            + ((longint'(kd) * d) >>> 8);
      if (total > 32767) total = 32767;
      if (total < -32768) total = -32768;
      r.err = e[16:0];
      r.acc = acc[31:0];
      r.sum = total[15:0];
      return r;
   endfunction

   always @(posedge clock) begin : watch
      req_payload_type rq;
      rsp_payload_type want;
      rsp_payload_type got;
      loop_step_type   st;
      longint          lvl;
      if (reset) begin
         foreach (gain_reg[i]) gain_reg[i] = '0;
         drive_hi_q  = DRIVE_UPPER_RESET;
         drive_lo_q  = DRIVE_LOWER_RESET;
         angle_err_q = '0;
         angle_acc_q = '0;
         speed_err_q = '0;
         speed_acc_q = '0;
         speed_ref_q = '0;
         drive_q     = '0;
         fail_count  = 0;
         loop_results_due.delete();
         pending_count <= 0;
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.payload.addr)
               CSR_DRIVE_UPPER_LIMIT: drive_hi_q = csr_mon.payload.wdata;
               CSR_DRIVE_LOWER_LIMIT: drive_lo_q = csr_mon.payload.wdata;
               default: gain_reg[csr_mon.payload.addr] = csr_mon.payload.wdata;
            endcase
         end

         if (req_mon.valid && req_mon.ready) begin
            rq = req_mon.payload;
            if (rq.opcode == OP_ANGLE) begin
               st = pid_loop_step(rq.angle_setpoint, rq.measured_angle,
                                  gain_reg[CSR_ANGLE_P_GAIN], gain_reg[CSR_ANGLE_I_GAIN],
                                  gain_reg[CSR_ANGLE_D_GAIN], angle_err_q, angle_acc_q,
                                  ANGLE_INT_HIGH, ANGLE_INT_LOW);
               angle_err_q = st.err;
               angle_acc_q = st.acc;
               lvl = longint'(st.sum);
               if (lvl >= longint'(SPEED_SET_HIGH)) lvl = longint'(SPEED_SET_HIGH);
               if (lvl <= longint'(SPEED_SET_LOW)) lvl = longint'(SPEED_SET_LOW);
               speed_ref_q   = lvl[15:0];
               want.loop_ran = 1'b0;
            end else begin
               // bit 1 of the opcode loads the external target first
               if (rq.opcode[1]) speed_ref_q = rq.external_speed_setpoint;
               st = pid_loop_step(speed_ref_q, rq.measured_speed,
                                  gain_reg[CSR_SPEED_P_GAIN], gain_reg[CSR_SPEED_I_GAIN],
                                  gain_reg[CSR_SPEED_D_GAIN], speed_err_q, speed_acc_q,
                                  SPEED_INT_HIGH, SPEED_INT_LOW);
               speed_err_q = st.err;
               speed_acc_q = st.acc;
               // upper clamp first, so crossed limits end on the lower one
               lvl = longint'(st.sum);
               if (lvl >= longint'(drive_hi_q)) lvl = longint'(drive_hi_q);
               if (lvl <= longint'(drive_lo_q)) lvl = longint'(drive_lo_q);
               drive_q       = lvl[15:0];
               want.loop_ran = 1'b1;
            end
            want.speed_setpoint_now = speed_ref_q;
            want.drive_value        = drive_q;
            loop_results_due.push_back(want);
         end

         if (rsp_mon.valid && rsp_mon.ready) begin
            got = rsp_mon.payload;
            if (loop_results_due.size() == 0) begin
               if (fail_count < 10)
                  $display("[%0t] unexpected result transaction: loop %0d",
                           $realtime, got.loop_ran,
                           " target %0d drive %0d",
                           $signed(got.speed_setpoint_now), $signed(got.drive_value));
               fail_count++;
            end else begin
               want = loop_results_due.pop_front();
               if (got.loop_ran !== want.loop_ran
                   || got.speed_setpoint_now !== want.speed_setpoint_now
                   || got.drive_value !== want.drive_value) begin
                  if (fail_count < 10)
                     $display("[%0t] mismatch: loop exp %0d got %0d,",
                              $realtime, want.loop_ran, got.loop_ran,
                              " target exp %0d got %0d,",
                              $signed(want.speed_setpoint_now),
                              $signed(got.speed_setpoint_now),
                              " drive exp %0d got %0d",
                              $signed(want.drive_value), $signed(got.drive_value));
                  fail_count++;
               end
            end
         end

         pending_count <= loop_results_due.size();
      end
   end

endmodule

[bench/cascaded_pid_angle_speed_test.sv]
// testbench top for cascaded_pid_angle_speed: clock, reset, register writes and
// request stimulus with random idling; checking is done by pid_response_checker
// depends on cpas_pkg, cpas_channels, the block and bench/pid_response_checker.sv
module cascaded_pid_angle_speed_test;
   import cpas_pkg::*;

   // opcode 3 decodes like the load-and-run opcode
   localparam logic [1:0] OP_LOAD_ALT = 2'd3;
   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_ITEMS   = 150;

   typedef enum int {MIX_FREE, WIND_UP, WIND_DOWN} stim_mode_type;

   logic clock = 1'b0;
   logic reset;
   logic idle_on;
   int   stall_left = 0;
   int   fail_count;
   int   pending_count;

   cpas_req_if req_chan ();
   cpas_rsp_if rsp_chan ();
   cpas_csr_if csr_chan ();

   cascaded_pid_angle_speed u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   pid_response_checker u_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .csr_mon       (csr_chan),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      #4000000;
      $display("simulation failed");
      $finish;
   end

   // result side back-pressure in bursts
   always @(posedge clock) begin
      if (!idle_on) begin
         stall_left     <= 0;
         rsp_chan.ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left     <= stall_left - 1;
         rsp_chan.ready <= 1'b0;
      end else if ($urandom_range(0, 11) == 0) begin
         stall_left     <= $urandom_range(0, 17);
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   task automatic send_transaction(input req_payload_type item);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.payload <= item;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic send_item(input logic [1:0] op, input logic signed [15:0] aset,
                            input logic signed [15:0] ameas, input logic signed [15:0] smeas,
                            input logic signed [15:0] sext);
      req_payload_type item;
      item.opcode                  = op;
      item.angle_setpoint          = aset;
      item.measured_angle          = ameas;
      item.measured_speed          = smeas;
      item.external_speed_setpoint = sext;
      send_transaction(item);
   endtask

   task automatic write_settings(input logic signed [15:0] a_p, input logic signed [15:0] a_i,
                                 input logic signed [15:0] a_d, input logic signed [15:0] s_p,
                                 input logic signed [15:0] s_i, input logic signed [15:0] s_d,
                                 input logic signed [15:0] hi, input logic signed [15:0] lo);
      logic signed [15:0] vals [CSR_ANGLE_P_GAIN:CSR_DRIVE_LOWER_LIMIT];
      vals[CSR_ANGLE_P_GAIN]      = a_p;
      vals[CSR_ANGLE_I_GAIN]      = a_i;
      vals[CSR_ANGLE_D_GAIN]      = a_d;
      vals[CSR_SPEED_P_GAIN]      = s_p;
      vals[CSR_SPEED_I_GAIN]      = s_i;
      vals[CSR_SPEED_D_GAIN]      = s_d;
      vals[CSR_DRIVE_UPPER_LIMIT] = hi;
      vals[CSR_DRIVE_LOWER_LIMIT] = lo;
      for (int i = int'(CSR_ANGLE_P_GAIN); i <= int'(CSR_DRIVE_LOWER_LIMIT); i++) begin
         csr_chan.valid         <= 1'b1;
         csr_chan.payload.addr  <= CSR_ADDR_W'(i);
         csr_chan.payload.wdata <= vals[i];
         @(posedge clock);
         while (!csr_chan.ready) @(posedge clock);
      end
      csr_chan.valid <= 1'b0;
   endtask

   task automatic drain_results();
      do @(posedge clock); while (pending_count != 0);
   endtask

   function automatic logic signed [15:0] any_word();
      case ($urandom_range(0, 7))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2, 3:    return 16'($urandom_range(0, 128) - 64);
         default: return 16'($urandom());
      endcase
   endfunction

   // upper half 16384..32767, otherwise -32768..-16385
   function automatic logic signed [15:0] far_word(input bit upper);
      return upper ? 16'($urandom_range(16384, 32767)) : 16'($urandom_range(32768, 49151));
   endfunction

   function automatic logic signed [15:0] pick_gain();
      case ($urandom_range(0, 9))
         0:          return 16'sh7FFF;
         1:          return 16'sh8000;
         2:          return 16'sh0000;
         3, 4, 5, 6: return 16'($urandom_range(0, 2048) - 1024);
         default:    return 16'($urandom());
      endcase
   endfunction

   function automatic req_payload_type make_item(input stim_mode_type mode);
      req_payload_type item;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: item.opcode = OP_ANGLE;
         4, 5, 6:    item.opcode = OP_SPEED;
         7, 8:       item.opcode = OP_LOAD_SPEED;
         default:    item.opcode = OP_LOAD_ALT;
      endcase
      if (mode == MIX_FREE || $urandom_range(0, 4) == 0) begin
         item.angle_setpoint          = any_word();
         item.measured_angle          = any_word();
         item.measured_speed          = any_word();
         item.external_speed_setpoint = any_word();
      end else begin
         // same-sign large errors to drive the integrals into their clamps
         item.angle_setpoint          = far_word(mode == WIND_UP);
         item.measured_angle          = far_word(mode != WIND_UP);
         item.measured_speed          = far_word(mode != WIND_UP);
         item.external_speed_setpoint = far_word(mode == WIND_UP);
      end
      return item;
   endfunction

   initial begin : stimulus
      stim_mode_type      mode;
      logic signed [15:0] hi;
      logic signed [15:0] lo;
      reset            <= 1'b1;
      idle_on          <= 1'b1;
      req_chan.valid   <= 1'b0;
      req_chan.payload <= '0;
      csr_chan.valid   <= 1'b0;
      csr_chan.payload <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // field extremes and every opcode with moderate gains
      write_settings(16'sd256, 16'sd16, 16'sd128, 16'sd256, 16'sd16, -16'sd128,
                     DRIVE_UPPER_RESET, DRIVE_LOWER_RESET);
      send_item(OP_ANGLE, 16'sh7FFF, 16'sh8000, 16'sd0, 16'sd0);
      send_item(OP_ANGLE, 16'sh8000, 16'sh7FFF, 16'sd0, 16'sd0);
      send_item(OP_ANGLE, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
      send_item(OP_SPEED, 16'sd0, 16'sd0, 16'sh8000, 16'sd0);
      send_item(OP_SPEED, 16'sd0, 16'sd0, 16'sh7FFF, 16'sd0);
      send_item(OP_LOAD_SPEED, 16'sd0, 16'sd0, 16'sh8000, 16'sh7FFF);
      send_item(OP_LOAD_SPEED, 16'sd0, 16'sd0, 16'sh7FFF, 16'sh8000);
      send_item(OP_LOAD_ALT, 16'sd0, 16'sd0, -16'sd5, 16'sd1234);
      send_item(OP_ANGLE, 16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA);
      send_item(OP_LOAD_SPEED, 16'shAAAA, 16'sh5555, 16'sd0, 16'sd0);
      req_chan.valid <= 1'b0;
      drain_results();

      // extreme gains and crossed drive limits
      write_settings(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000,
                     -16'sd100, 16'sd100);
      send_item(OP_SPEED, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
      send_item(OP_LOAD_SPEED, 16'sd0, 16'sd0, -16'sd500, 16'sd500);
      send_item(OP_ANGLE, 16'sd100, -16'sd100, 16'sd0, 16'sd0);
      send_item(OP_LOAD_ALT, 16'sd0, 16'sd0, 16'sh7FFF, 16'sh8000);
      req_chan.valid <= 1'b0;
      drain_results();

      // narrow drive window, zero angle gains
      write_settings(16'sd0, 16'sd0, 16'sd0, 16'sd256, 16'sd0, 16'sd0, 16'sd200, -16'sd200);
      send_item(OP_LOAD_SPEED, 16'sd0, 16'sd0, 16'sd0, 16'sh7FFF);
      send_item(OP_LOAD_SPEED, 16'sd0, 16'sd0, 16'sd0, 16'sh8000);
      send_item(OP_SPEED, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
      send_item(OP_ANGLE, 16'sd1, 16'sd0, 16'sd0, 16'sd0);
      req_chan.valid <= 1'b0;
      drain_results();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase == RANDOM_PHASES - 1) idle_on <= 1'b0;
         case (phase)
            1:       mode = WIND_UP;
            3:       mode = WIND_DOWN;
            default: mode = MIX_FREE;
         endcase
         case ($urandom_range(0, 4))
            0: begin
               hi = DRIVE_UPPER_RESET;
               lo = DRIVE_LOWER_RESET;
            end
            1: begin
               hi = 16'sh8000;
               lo = 16'sh7FFF;
            end
            2: begin
               hi = 16'($urandom_range(0, 4000) - 2000);
               lo = 16'($urandom_range(0, 4000) - 2000);
            end
            3: begin
               hi = 16'($urandom_range(1, 300));
               lo = -hi;
            end
            default: begin
               hi = 16'($urandom());
               lo = 16'($urandom());
            end
         endcase
         write_settings(pick_gain(), pick_gain(), pick_gain(), pick_gain(), pick_gain(),
                        pick_gain(), hi, lo);
         for (int n = 0; n < PHASE_ITEMS; n++) send_transaction(make_item(mode));
         req_chan.valid <= 1'b0;
         drain_results();
      end

      repeat (8) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
